FILE: rtl/bfsp_pkg.sv
`default_nettype none
package bfsp_pkg;
  localparam int VCNT_W = 5;
  localparam int VID_W = 4;
  localparam int COST_W = 16;
  localparam int DIST_W = 24;
  localparam int STAT_W = 3;
  localparam int OP_W = 2;
  localparam int DEF_MAX_VERTICES = 16;
  localparam int DEF_MAX_EDGES = 64;

  localparam logic [OP_W-1:0] OP_ADD = 2'd0;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK = 3'd0;
  localparam logic [STAT_W-1:0] ST_NEG_CYCLE = 3'd1;
  localparam logic [STAT_W-1:0] ST_UNREACH = 3'd2;
  localparam logic [STAT_W-1:0] ST_BAD_VERTEX = 3'd3;
  localparam logic [STAT_W-1:0] ST_FULL = 3'd4;

  localparam logic signed [DIST_W-1:0] DIST_MAX = 24'sh7FFFFF;
  localparam logic signed [DIST_W-1:0] DIST_MIN = 24'sh800000;

  function automatic logic signed [DIST_W-1:0] sat24(input logic signed [DIST_W+1:0] v);
    if (v > 26'sd8388607) begin
      return DIST_MAX;
    end else if (v < -26'sd8388608) begin
      return DIST_MIN;
    end
    return v[DIST_W-1:0];
  endfunction
endpackage
`default_nettype wire

FILE: rtl/bfsp_if.sv
`default_nettype none
interface bfsp_in_if import bfsp_pkg::*; ();
  logic valid;
  logic ready;
  logic [OP_W-1:0] opcode;
  logic [VID_W-1:0] edge_source;
  logic [VID_W-1:0] edge_dest;
  logic signed [COST_W-1:0] edge_cost;
  logic [VID_W-1:0] query_source;
  logic [VID_W-1:0] query_target;
  modport source (output valid, opcode, edge_source, edge_dest, edge_cost, query_source,
                  query_target, input ready);
  modport sink (input valid, opcode, edge_source, edge_dest, edge_cost, query_source,
                query_target, output ready);
endinterface

interface bfsp_out_if import bfsp_pkg::*; ();
  logic valid;
  logic ready;
  logic [STAT_W-1:0] status;
  logic [VID_W-1:0] hop_source;
  logic [VID_W-1:0] hop_dest;
  logic signed [COST_W-1:0] hop_cost;
  logic signed [DIST_W-1:0] running_distance;
  logic last;
  modport source (output valid, status, hop_source, hop_dest, hop_cost, running_distance,
                  last, input ready);
  modport sink (input valid, status, hop_source, hop_dest, hop_cost, running_distance,
                last, output ready);
endinterface
`default_nettype wire

FILE: rtl/bfsp_ram.sv
`default_nettype none
module bfsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int ADDR_W = 4
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

FILE: rtl/bellman_ford_shortest_path_unit.sv
`default_nettype none
// channel | dir | payload                                              | transaction
// in_ch   | in  | opcode, edge_source/dest/cost, query_source/target   | valid & ready
// out_ch  | out | status, hop_source/dest/cost, running_distance, last | valid & ready
// apb     | in  | vertex_count at address 0                            | psel & penable & pwrite
//
// add and clear go straight to the result; a query runs vertex_count-1 relaxation passes
// over the stored edges plus a check pass, walks the predecessors, then for each path
// hop reads both hop distances and scans the stored edges to find the hop weight. the
// distance memory has a single read port.
// rst is synchronous and clears the edge count, reached bits and control state.
// a stalled output holds the sequencer; input is taken only while idle.
module bellman_ford_shortest_path_unit import bfsp_pkg::*; #(
  parameter int MAX_VERTICES = DEF_MAX_VERTICES,
  parameter int MAX_EDGES = DEF_MAX_EDGES
) (
  input  wire logic        clk,
  input  wire logic        rst,
  bfsp_in_if.sink          in_ch,
  bfsp_out_if.source       out_ch,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);
  localparam int VW = $clog2(MAX_VERTICES);
  localparam int EW = $clog2(MAX_EDGES + 1);
  localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int VC_RST = (MAX_VERTICES < 16) ? MAX_VERTICES : 16;
  localparam int EDGE_WW = 2 * VID_W + COST_W;
  localparam int DIST_WW = VID_W + DIST_W;

  typedef enum logic [4:0] {
    S_IDLE, S_RESULT, S_INIT, S_R_EA, S_R_ED, S_R_DA, S_R_DB, S_CHK_END,
    S_W_CHK, S_W_GOT, S_P_A, S_P_B, S_P_C, S_P_D, S_P_E, S_P_SCAN, S_P_EMIT
  } state_t;

  state_t state;
  logic [VCNT_W-1:0] vertex_count;
  logic [EW-1:0] edges_loaded;
  logic [EW-1:0] e;
  logic [VCNT_W-1:0] pass;
  logic chk;
  logic [MAX_VERTICES-1:0] reached;
  logic [VID_W-1:0] qsrc, qdst, ea, eb, v, hop_a, hop_b;
  logic signed [COST_W-1:0] ec;
  logic signed [DIST_W-1:0] da, db, run;
  logic signed [DIST_W:0] cost;
  logic [VCNT_W-1:0] len, i;

  logic [STAT_W-1:0] res_status;
  logic [VID_W-1:0] res_hs, res_hd;
  logic signed [COST_W-1:0] res_cost;
  logic signed [DIST_W-1:0] res_dist;
  logic res_last;

  logic edge_we;
  logic [EAW-1:0] edge_raddr;
  logic [EDGE_WW-1:0] edge_rdata;
  logic dist_we;
  logic [VW-1:0] dist_waddr, dist_raddr;
  logic [DIST_WW-1:0] dist_wdata, dist_rdata;
  logic path_we;
  logic [VW-1:0] path_waddr, path_raddr;
  logic [VID_W-1:0] path_wdata, path_rdata;

  logic [VID_W-1:0] rd_src, rd_dst, rd_pred;
  logic signed [COST_W-1:0] rd_cost;
  logic signed [DIST_W-1:0] rd_dist;
  logic signed [DIST_W:0] sum;
  logic relax_hit, usable, last_edge, cfg_wr;
  logic [4:0] cfg_v;

  function automatic logic [VW-1:0] vidx(input logic [VID_W-1:0] x);
    return VW'(x);
  endfunction

  assign rd_src = edge_rdata[EDGE_WW-1 -: VID_W];
  assign rd_dst = edge_rdata[COST_W +: VID_W];
  assign rd_cost = edge_rdata[COST_W-1:0];
  assign rd_pred = dist_rdata[DIST_WW-1 -: VID_W];
  assign rd_dist = dist_rdata[DIST_W-1:0];

  // exact sum, the check pass must not be fooled by saturation
  assign sum = {da[DIST_W-1], da} + {{(DIST_W + 1 - COST_W){ec[COST_W-1]}}, ec};
  assign relax_hit = !reached[vidx(eb)] || (sum < $signed({rd_dist[DIST_W-1], rd_dist}));
  assign usable = (5'(rd_src) < vertex_count) && (5'(rd_dst) < vertex_count) &&
                  reached[vidx(rd_src)];
  assign last_edge = (e + EW'(1)) == edges_loaded;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign cfg_v = pwdata[4:0];
  assign prdata = (paddr[2] == 1'b0) ? {27'd0, vertex_count} : 32'd0;
  assign in_ch.ready = (state == S_IDLE);

  bfsp_ram #(.WIDTH(EDGE_WW), .DEPTH(MAX_EDGES), .ADDR_W(EAW)) u_edge_ram (
    .clk(clk), .we(edge_we), .waddr(EAW'(edges_loaded)),
    .wdata({in_ch.edge_source, in_ch.edge_dest, in_ch.edge_cost}),
    .raddr(edge_raddr), .rdata(edge_rdata)
  );

  bfsp_ram #(.WIDTH(DIST_WW), .DEPTH(MAX_VERTICES), .ADDR_W(VW)) u_dist_ram (
    .clk(clk), .we(dist_we), .waddr(dist_waddr), .wdata(dist_wdata),
    .raddr(dist_raddr), .rdata(dist_rdata)
  );

  bfsp_ram #(.WIDTH(VID_W), .DEPTH(MAX_VERTICES), .ADDR_W(VW)) u_path_ram (
    .clk(clk), .we(path_we), .waddr(path_waddr), .wdata(path_wdata),
    .raddr(path_raddr), .rdata(path_rdata)
  );

  always_comb begin
    edge_we = 1'b0;
    if (state == S_IDLE && in_ch.valid && in_ch.opcode == OP_ADD &&
        5'(in_ch.edge_source) < vertex_count && 5'(in_ch.edge_dest) < vertex_count &&
        int'(edges_loaded) < MAX_EDGES) begin
      edge_we = 1'b1;
    end
  end

  always_comb begin
    unique case (state)
      S_P_E:    edge_raddr = '0;
      S_P_SCAN: edge_raddr = EAW'(e + EW'(1));
      default:  edge_raddr = EAW'(e);
    endcase
  end

  always_comb begin
    unique case (state)
      S_R_ED:  dist_raddr = vidx(rd_src);
      S_R_DA:  dist_raddr = vidx(eb);
      S_P_C:   dist_raddr = vidx(hop_a);
      S_P_D:   dist_raddr = vidx(hop_b);
      default: dist_raddr = vidx(v);
    endcase
  end

  always_comb begin
    dist_we = 1'b0;
    dist_waddr = vidx(eb);
    dist_wdata = {ea, sat24({sum[DIST_W], sum})};
    if (state == S_INIT) begin
      dist_we = 1'b1;
      dist_waddr = vidx(qsrc);
      dist_wdata = '0;
    end else if (state == S_R_DB && !chk && relax_hit) begin
      dist_we = 1'b1;
    end
  end

  always_comb begin
    path_we = 1'b0;
    path_waddr = '0;
    path_wdata = qdst;
    if (state == S_CHK_END) begin
      path_we = reached[vidx(qdst)] && (qdst != qsrc);
    end else if (state == S_W_GOT) begin
      path_we = 1'b1;
      path_waddr = VW'(len);
      path_wdata = rd_pred;
    end
    unique case (state)
      S_P_B:   path_raddr = VW'(i - VCNT_W'(1));
      default: path_raddr = VW'(i);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      vertex_count <= VCNT_W'(VC_RST);
      edges_loaded <= '0;
      reached <= '0;
      out_ch.valid <= 1'b0;
    end else begin
      if (cfg_wr && paddr[2] == 1'b0) begin
        if (cfg_v == 5'd0) begin
          vertex_count <= VCNT_W'(1);
        end else if (int'(cfg_v) > MAX_VERTICES) begin
          vertex_count <= VCNT_W'(MAX_VERTICES);
        end else begin
          vertex_count <= cfg_v;
        end
      end
      if (out_ch.valid && out_ch.ready && state != S_RESULT) begin
        out_ch.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          res_hs <= '0;
          res_hd <= '0;
          res_cost <= '0;
          res_dist <= '0;
          res_last <= 1'b1;
          res_status <= ST_OK;
          qsrc <= in_ch.query_source;
          qdst <= in_ch.query_target;
          if (in_ch.valid) begin
            priority case (in_ch.opcode)
              OP_ADD: begin
                state <= S_RESULT;
                if (5'(in_ch.edge_source) >= vertex_count ||
                    5'(in_ch.edge_dest) >= vertex_count) begin
                  res_status <= ST_BAD_VERTEX;
                end else if (int'(edges_loaded) >= MAX_EDGES) begin
                  res_status <= ST_FULL;
                end else begin
                  edges_loaded <= edges_loaded + EW'(1);
                end
              end
              OP_QUERY: begin
                if (5'(in_ch.query_source) >= vertex_count ||
                    5'(in_ch.query_target) >= vertex_count) begin
                  res_status <= ST_BAD_VERTEX;
                  state <= S_RESULT;
                end else begin
                  state <= S_INIT;
                end
              end
              OP_CLEAR: begin
                edges_loaded <= '0;
                state <= S_RESULT;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_INIT: begin
          reached <= MAX_VERTICES'(1) << vidx(qsrc);
          e <= '0;
          pass <= '0;
          chk <= (vertex_count == VCNT_W'(1));
          state <= (edges_loaded == '0) ? S_CHK_END : S_R_EA;
        end
        S_R_EA: state <= S_R_ED;
        S_R_ED: begin
          ea <= rd_src;
          eb <= rd_dst;
          ec <= rd_cost;
          if (usable) begin
            state <= S_R_DA;
          end else if (!last_edge) begin
            e <= e + EW'(1);
            state <= S_R_EA;
          end else if (chk) begin
            state <= S_CHK_END;
          end else begin
            e <= '0;
            pass <= pass + VCNT_W'(1);
            chk <= ({1'b0, pass} + 6'd2) >= {1'b0, vertex_count};
            state <= S_R_EA;
          end
        end
        S_R_DA: begin
          da <= rd_dist;
          state <= S_R_DB;
        end
        S_R_DB: begin
          if (chk && relax_hit) begin
            res_status <= ST_NEG_CYCLE;
            state <= S_RESULT;
          end else begin
            if (!chk && relax_hit) begin
              reached[vidx(eb)] <= 1'b1;
            end
            if (!last_edge) begin
              e <= e + EW'(1);
              state <= S_R_EA;
            end else if (chk) begin
              state <= S_CHK_END;
            end else begin
              e <= '0;
              pass <= pass + VCNT_W'(1);
              chk <= ({1'b0, pass} + 6'd2) >= {1'b0, vertex_count};
              state <= S_R_EA;
            end
          end
        end
        S_CHK_END: begin
          v <= qdst;
          len <= VCNT_W'(1);
          if (!reached[vidx(qdst)]) begin
            res_status <= ST_UNREACH;
            state <= S_RESULT;
          end else if (qdst == qsrc) begin
            res_hs <= qsrc;
            res_hd <= qsrc;
            state <= S_RESULT;
          end else begin
            state <= S_W_CHK;
          end
        end
        S_W_CHK: begin
          if (v == qsrc) begin
            i <= len - VCNT_W'(1);
            run <= '0;
            state <= S_P_A;
          end else if (len >= vertex_count) begin
            res_status <= ST_NEG_CYCLE;
            state <= S_RESULT;
          end else begin
            state <= S_W_GOT;
          end
        end
        S_W_GOT: begin
          v <= rd_pred;
          len <= len + VCNT_W'(1);
          state <= S_W_CHK;
        end
        S_P_A: state <= S_P_B;
        S_P_B: begin
          hop_a <= path_rdata;
          state <= S_P_C;
        end
        S_P_C: begin
          hop_b <= path_rdata;
          state <= S_P_D;
        end
        S_P_D: begin
          da <= rd_dist;
          state <= S_P_E;
        end
        S_P_E: begin
          db <= rd_dist;
          cost <= {rd_dist[DIST_W-1], rd_dist} - {da[DIST_W-1], da};
          e <= '0;
          state <= (edges_loaded == '0) ? S_P_EMIT : S_P_SCAN;
        end
        S_P_SCAN: begin
          // first stored edge that lies on the shortest path supplies the weight
          if (rd_src == hop_a && rd_dst == hop_b &&
              ({da[DIST_W-1], da} + {{(DIST_W + 1 - COST_W){rd_cost[COST_W-1]}}, rd_cost})
              == {db[DIST_W-1], db}) begin
            cost <= {{(DIST_W + 1 - COST_W){rd_cost[COST_W-1]}}, rd_cost};
            state <= S_P_EMIT;
          end else if (last_edge) begin
            state <= S_P_EMIT;
          end else begin
            e <= e + EW'(1);
          end
        end
        S_P_EMIT: begin
          run <= sat24({{2{run[DIST_W-1]}}, run} + {cost[DIST_W], cost});
          res_dist <= sat24({{2{run[DIST_W-1]}}, run} + {cost[DIST_W], cost});
          res_hs <= hop_a;
          res_hd <= hop_b;
          res_cost <= cost[COST_W-1:0];
          res_status <= ST_OK;
          res_last <= (i == VCNT_W'(1));
          state <= S_RESULT;
        end
        S_RESULT: begin
          if (!out_ch.valid || out_ch.ready) begin
            out_ch.valid <= 1'b1;
            out_ch.status <= res_status;
            out_ch.hop_source <= res_hs;
            out_ch.hop_dest <= res_hd;
            out_ch.hop_cost <= res_cost;
            out_ch.running_distance <= res_dist;
            out_ch.last <= res_last;
            if (res_last) begin
              state <= S_IDLE;
            end else begin
              i <= i - VCNT_W'(1);
              state <= S_P_A;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_edges_bounded: assert property (@(posedge clk) disable iff (rst)
    int'(edges_loaded) <= MAX_EDGES)
    else $error("edge count beyond table depth");

  a_source_reached: assert property (@(posedge clk) disable iff (rst)
    (state == S_R_EA || state == S_R_DB) |-> reached[vidx(qsrc)])
    else $error("query source lost its reached bit");

  a_cmd_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready && (in_ch.opcode == OP_ADD || in_ch.opcode == OP_QUERY ||
     in_ch.opcode == OP_CLEAR)) |=> (state != S_IDLE))
    else $error("accepted command produced no work");
endmodule
`default_nettype wire
